// ===== src/scbm_pkg.sv =====
package scbm_pkg;

  typedef struct packed {
    logic signed [23:0] sample_in;
    logic               channel_in;
    logic               block_end;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [23:0] sample_out;
    logic               channel_out;
    logic [57:0]        energy_left;
    logic [57:0]        energy_right;
    logic [23:0]        peak_left;
    logic [23:0]        peak_right;
    logic [12:0]        frame_count;
    logic               clip_flag;
    logic               run_last;
  } result_t;

  typedef struct packed {
    logic [23:0]        drive_gain;
    logic [16:0]        makeup_gain;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
  } cfg_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd6;

  localparam logic [23:0]        DRIVE_RST  = 24'd65536;
  localparam logic [16:0]        MAKEUP_RST = 17'd65536;
  localparam logic signed [31:0] B0_RST     = 32'sd1073741824;

  localparam logic [12:0]        FRAME_CAP  = 13'd4096;
  localparam logic [23:0]        DRIVE_14DB = 24'd328458;
  localparam logic [23:0]        PEAK_098   = 24'd8220835;
  localparam logic [13:0]        CUBIC_K    = 14'd9830;
  localparam logic signed [47:0] SHAPE_LIM  = 48'sd35184372088832;

  // multiplier operand pairs
  localparam logic [3:0] MUL_NONE = 4'd0;
  localparam logic [3:0] MUL_XD   = 4'd1;
  localparam logic [3:0] MUL_MM   = 4'd2;
  localparam logic [3:0] MUL_SQH  = 4'd3;
  localparam logic [3:0] MUL_SQL  = 4'd4;
  localparam logic [3:0] MUL_CL   = 4'd5;
  localparam logic [3:0] MUL_CH   = 4'd6;
  localparam logic [3:0] MUL_SL   = 4'd7;
  localparam logic [3:0] MUL_SH   = 4'd8;
  localparam logic [3:0] MUL_B0   = 4'd9;
  localparam logic [3:0] MUL_B1   = 4'd10;
  localparam logic [3:0] MUL_B2   = 4'd11;
  localparam logic [3:0] MUL_A1   = 4'd12;
  localparam logic [3:0] MUL_A2   = 4'd13;
  localparam logic [3:0] MUL_YY   = 4'd14;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_20 = 2'd1;
  localparam logic [1:0] SH_24 = 2'd2;

  localparam logic [2:0] CAP_NONE = 3'd0;
  localparam logic [2:0] CAP_U    = 3'd1;
  localparam logic [2:0] CAP_SQ   = 3'd2;
  localparam logic [2:0] CAP_C    = 3'd3;
  localparam logic [2:0] CAP_S    = 3'd4;
  localparam logic [2:0] CAP_F    = 3'd5;
  localparam logic [2:0] CAP_Y    = 3'd6;
  localparam logic [2:0] CAP_E    = 3'd7;

  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_SAMPLE = 2'd1;
  localparam logic [1:0] OUT_TELE   = 2'd2;

  localparam logic [1:0] JMP_NEXT   = 2'd0;
  localparam logic [1:0] JMP_ACCEPT = 2'd1;
  localparam logic [1:0] JMP_EMIT   = 2'd2;
  localparam logic [1:0] JMP_DONE   = 2'd3;

  typedef struct packed {
    logic [3:0] mul;
    logic [1:0] acc;
    logic [1:0] shift;
    logic [2:0] cap;
    logic [1:0] out;
  } ctl_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [1:0] jmp;
  } uword_t;

  function automatic logic signed [23:0] sat24(input logic signed [55:0] v);
    logic signed [23:0] r;
    if (v > 56'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -56'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== src/scbm_seq.sv =====
module scbm_seq import scbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_free,
  input  logic last,
  output logic busy,
  output ctl_t ctl
);

  localparam int SW = 5;

  logic [SW-1:0] step, step_next;
  uword_t        uw;

  function automatic uword_t mk(input logic [3:0] mul, input logic [1:0] acc,
                                input logic [1:0] sh, input logic [2:0] cap,
                                input logic [1:0] out, input logic [1:0] jmp);
    uword_t w;
    w.ctl.mul   = mul;
    w.ctl.acc   = acc;
    w.ctl.shift = sh;
    w.ctl.cap   = cap;
    w.ctl.out   = out;
    w.jmp       = jmp;
    return w;
  endfunction

  // product lands in preg in the step after its MUL, acc in the step after that
  function automatic uword_t urom(input logic [SW-1:0] a);
    uword_t w;
    case (a)
      5'd0:  w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_ACCEPT);
      5'd1:  w = mk(MUL_XD,   ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd2:  w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_U,    OUT_NONE,   JMP_NEXT);
      5'd3:  w = mk(MUL_MM,   ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd4:  w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_SQ,   OUT_NONE,   JMP_NEXT);
      5'd5:  w = mk(MUL_SQH,  ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd6:  w = mk(MUL_SQL,  ACC_LOAD, SH_20, CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd7:  w = mk(MUL_NONE, ACC_ADD,  SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd8:  w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_C,    OUT_NONE,   JMP_NEXT);
      5'd9:  w = mk(MUL_CL,   ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd10: w = mk(MUL_CH,   ACC_LOAD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd11: w = mk(MUL_NONE, ACC_ADD,  SH_24, CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd12: w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_S,    OUT_NONE,   JMP_NEXT);
      5'd13: w = mk(MUL_SL,   ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd14: w = mk(MUL_SH,   ACC_LOAD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd15: w = mk(MUL_NONE, ACC_ADD,  SH_24, CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd16: w = mk(MUL_B1,   ACC_HOLD, SH_0,  CAP_F,    OUT_NONE,   JMP_NEXT);
      5'd17: w = mk(MUL_B2,   ACC_LOAD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd18: w = mk(MUL_A1,   ACC_ADD,  SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd19: w = mk(MUL_A2,   ACC_SUB,  SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd20: w = mk(MUL_B0,   ACC_SUB,  SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd21: w = mk(MUL_NONE, ACC_ADD,  SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd22: w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_Y,    OUT_NONE,   JMP_NEXT);
      5'd23: w = mk(MUL_YY,   ACC_HOLD, SH_0,  CAP_NONE, OUT_NONE,   JMP_NEXT);
      5'd24: w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_E,    OUT_NONE,   JMP_NEXT);
      5'd25: w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_NONE, OUT_SAMPLE, JMP_EMIT);
      5'd26: w = mk(MUL_NONE, ACC_HOLD, SH_0,  CAP_NONE, OUT_TELE,   JMP_DONE);
      default: w = mk(MUL_NONE, ACC_HOLD, SH_0, CAP_NONE, OUT_NONE,  JMP_DONE);
    endcase
    return w;
  endfunction

  assign uw   = urom(step);
  assign busy = (step != '0);

  always_comb begin
    ctl = uw.ctl;
    if (!out_free) begin
      ctl.out = OUT_NONE;
    end
  end

  always_comb begin
    unique case (uw.jmp)
      JMP_NEXT:   step_next = step + 5'd1;
      JMP_ACCEPT: step_next = start ? step + 5'd1 : step;
      JMP_EMIT:   step_next = !out_free ? step : (last ? step + 5'd1 : '0);
      JMP_DONE:   step_next = !out_free ? step : '0;
      default:    step_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== src/scbm_dp.sv =====
module scbm_dp import scbm_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  item_t   item,
  input  cfg_t    cfg,
  input  ctl_t    ctl,
  output logic    last,
  output result_t smp,
  output result_t tele
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [23:0] x;
  logic               ch;
  logic [CW-1:0]      ci;

  logic signed [31:0] u;
  logic [30:0]        m;
  logic [38:0]        sq;
  logic [46:0]        c;
  logic signed [46:0] s;
  logic signed [23:0] f;
  logic signed [23:0] y;
  logic [23:0]        mag;

  logic signed [32:0] opa, opb;
  logic signed [65:0] prod, preg;
  logic signed [71:0] pext, addend, acc, acc_next;
  logic signed [23:0] hist_rd;

  logic signed [23:0] xh0 [CHANNELS];
  logic signed [23:0] xh1 [CHANNELS];
  logic signed [23:0] yh0 [CHANNELS];
  logic signed [23:0] yh1 [CHANNELS];

  logic [57:0] energy [2];
  logic [23:0] peak [2];
  logic [12:0] frames;

  logic signed [31:0] u_new;
  logic [31:0]        u_neg;
  logic [44:0]        k;
  logic signed [47:0] u_w, k_w, s_raw, s_cl;
  logic signed [23:0] y_new;
  logic [24:0]        y_neg;
  logic [58:0]        e_sum;
  logic [23:0]        pk;

  assign ci = CW'(ch);

  always_comb begin
    unique case (ctl.mul)
      MUL_B1:  hist_rd = xh0[ci];
      MUL_B2:  hist_rd = xh1[ci];
      MUL_A1:  hist_rd = yh0[ci];
      MUL_A2:  hist_rd = yh1[ci];
      default: hist_rd = f;
    endcase
  end

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctl.mul)
      MUL_XD: begin
        opa = {{9{x[23]}}, x};
        opb = {9'b0, cfg.drive_gain};
      end
      MUL_MM: begin
        opa = {2'b0, m};
        opb = {2'b0, m};
      end
      MUL_SQH: begin
        opa = {14'b0, sq[38:20]};
        opb = {2'b0, m};
      end
      MUL_SQL: begin
        opa = {13'b0, sq[19:0]};
        opb = {2'b0, m};
      end
      MUL_CL: begin
        opa = {9'b0, c[23:0]};
        opb = {19'b0, CUBIC_K};
      end
      MUL_CH: begin
        opa = {10'b0, c[46:24]};
        opb = {19'b0, CUBIC_K};
      end
      MUL_SL: begin
        opa = {9'b0, s[23:0]};
        opb = {16'b0, cfg.makeup_gain};
      end
      MUL_SH: begin
        opa = {{10{s[46]}}, s[46:24]};
        opb = {16'b0, cfg.makeup_gain};
      end
      MUL_B0: begin
        opa = {cfg.coef_b0[31], cfg.coef_b0};
        opb = {{9{hist_rd[23]}}, hist_rd};
      end
      MUL_B1: begin
        opa = {cfg.coef_b1[31], cfg.coef_b1};
        opb = {{9{hist_rd[23]}}, hist_rd};
      end
      MUL_B2: begin
        opa = {cfg.coef_b2[31], cfg.coef_b2};
        opb = {{9{hist_rd[23]}}, hist_rd};
      end
      MUL_A1: begin
        opa = {cfg.coef_a1[31], cfg.coef_a1};
        opb = {{9{hist_rd[23]}}, hist_rd};
      end
      MUL_A2: begin
        opa = {cfg.coef_a2[31], cfg.coef_a2};
        opb = {{9{hist_rd[23]}}, hist_rd};
      end
      MUL_YY: begin
        opa = {9'b0, mag};
        opb = {9'b0, mag};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = opa * opb;
  assign pext = {{6{preg[65]}}, preg};

  always_comb begin
    unique case (ctl.shift)
      SH_0:    addend = pext;
      SH_20:   addend = pext <<< 20;
      SH_24:   addend = pext <<< 24;
      default: addend = pext;
    endcase
  end

  always_comb begin
    unique case (ctl.acc)
      ACC_LOAD: acc_next = addend;
      ACC_ADD:  acc_next = acc + addend;
      ACC_SUB:  acc_next = acc - addend;
      default:  acc_next = acc;
    endcase
  end

  // capture helpers
  always_comb begin
    u_new = preg[47:16];
    u_neg = -u_new;
    k     = acc[60:16];
    u_w   = {{16{u[31]}}, u};
    k_w   = {3'b0, k};
    s_raw = u[31] ? u_w + k_w : u_w - k_w;
    if (s_raw > SHAPE_LIM) begin
      s_cl = SHAPE_LIM;
    end else if (s_raw < -SHAPE_LIM) begin
      s_cl = -SHAPE_LIM;
    end else begin
      s_cl = s_raw;
    end
    y_new = sat24({{14{acc[71]}}, acc[71:30]});
    y_neg = -{y_new[23], y_new};
    e_sum = {1'b0, energy[ch]} + {12'b0, preg[46:0]};
    pk    = (peak[0] > peak[1]) ? peak[0] : peak[1];
  end

  always_ff @(posedge clk) begin
    preg <= prod;
    acc  <= acc_next;
    if (load) begin
      x    <= item.sample_in;
      ch   <= (CHANNELS > 1) ? item.channel_in : 1'b0;
      last <= item.block_end;
    end
    unique case (ctl.cap)
      CAP_U: begin
        u <= u_new;
        m <= u_new[31] ? u_neg[30:0] : u_new[30:0];
      end
      CAP_SQ: sq <= preg[61:23];
      CAP_C:  c <= acc[69:23];
      CAP_S:  s <= s_cl[46:0];
      CAP_F:  f <= sat24(acc[71:16]);
      CAP_Y: begin
        y   <= y_new;
        mag <= y_new[23] ? y_neg[23:0] : y_new;
      end
      default: begin
      end
    endcase
  end

  // filter history, cleared only by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        xh0[i] <= '0;
        xh1[i] <= '0;
        yh0[i] <= '0;
        yh1[i] <= '0;
      end
    end else if (ctl.cap == CAP_Y) begin
      xh1[ci] <= xh0[ci];
      xh0[ci] <= f;
      yh1[ci] <= yh0[ci];
      yh0[ci] <= y_new;
    end
  end

  // meters
  always_ff @(posedge clk) begin
    if (rst || ctl.out == OUT_TELE) begin
      energy[0] <= '0;
      energy[1] <= '0;
      peak[0]   <= '0;
      peak[1]   <= '0;
      frames    <= '0;
    end else if (ctl.cap == CAP_E) begin
      energy[ch] <= e_sum[58] ? '1 : e_sum[57:0];
      if (mag > peak[ch]) begin
        peak[ch] <= mag;
      end
      if (ch == 1'(CHANNELS - 1) && frames < FRAME_CAP) begin
        frames <= frames + 13'd1;
      end
    end
  end

  always_comb begin
    smp             = '0;
    smp.result_kind = 1'b0;
    smp.sample_out  = y;
    smp.channel_out = ch;
    smp.run_last    = !last;

    tele              = '0;
    tele.result_kind  = 1'b1;
    tele.energy_left  = energy[0];
    tele.energy_right = energy[1];
    tele.peak_left    = peak[0];
    tele.peak_right   = peak[1];
    tele.frame_count  = frames;
    tele.clip_flag    = (cfg.drive_gain > DRIVE_14DB) && (pk > PEAK_098);
    tele.run_last     = 1'b1;
  end

endmodule

// ===== src/soft_clip_biquad_meter.sv =====
// Drive, cubic soft clip, makeup gain and per-channel biquad with block
// metering. Each sample beat (Q1.23 plus channel tag) yields one filtered
// sample result; a sample marked block_end yields a second, telemetry result
// with per-channel energy and peak, frame count and clip flag, after which
// the meters clear (filter history does not). All multiplies share a single
// 33x33 signed multiplier feeding a 72-bit accumulator, stepped by a 27-word
// microprogram through fourteen products. A new sample beat is taken only when
// the microprogram is back at idle, and a stalled output holds it at its output
// steps; the result register lets the next sample enter while the previous
// result waits. Configuration writes are taken in any cycle and must only
// occur while the block is idle.
module soft_clip_biquad_meter import scbm_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t    cfg;
  ctl_t    ctl;
  logic    busy;
  logic    start;
  logic    out_free;
  logic    last;
  result_t smp, tele;

  assign cfg_ready  = 1'b1;
  assign item_stall = busy;
  assign start      = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_gain  <= DRIVE_RST;
      cfg.makeup_gain <= MAKEUP_RST;
      cfg.coef_b0     <= B0_RST;
      cfg.coef_b1     <= '0;
      cfg.coef_b2     <= '0;
      cfg.coef_a1     <= '0;
      cfg.coef_a2     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DRIVE:  cfg.drive_gain  <= cfg_data[23:0];
        REG_MAKEUP: cfg.makeup_gain <= cfg_data[16:0];
        REG_B0:     cfg.coef_b0     <= cfg_data;
        REG_B1:     cfg.coef_b1     <= cfg_data;
        REG_B2:     cfg.coef_b2     <= cfg_data;
        REG_A1:     cfg.coef_a1     <= cfg_data;
        REG_A2:     cfg.coef_a2     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  scbm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .last     (last),
    .busy     (busy),
    .ctl      (ctl)
  );

  scbm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .load (start),
    .item (item),
    .cfg  (cfg),
    .ctl  (ctl),
    .last (last),
    .smp  (smp),
    .tele (tele)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.out != OUT_NONE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out == OUT_SAMPLE) begin
      result <= smp;
    end else if (ctl.out == OUT_TELE) begin
      result <= tele;
    end
  end

endmodule

// ===== src/scbm_chk.sv =====
module scbm_chk import scbm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("result beat changed while stalled");

  // an accepted sample keeps the input side busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input not stalled after accepting a beat");

  // a sample closing a block is followed at once by its telemetry
  a_tele: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !result.run_last)
      |=> (result_valid && result.result_kind))
    else $error("telemetry did not follow block end sample");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.clip_flag)
      |-> (result.peak_left > PEAK_098 || result.peak_right > PEAK_098))
    else $error("clip flag without a peak above threshold");

endmodule

bind soft_clip_biquad_meter scbm_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import scbm_pkg::*;

  localparam logic LEFT  = 1'b0;
  localparam logic RIGHT = 1'b1;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint      CLIP_LIMIT  = 64'sd1 << 45;
  localparam logic [63:0] CUBE_K      = 64'd9830;
  localparam logic [63:0] ENERGY_CAP  = (64'd1 << 58) - 64'd1;
  localparam int          FRAME_LIMIT = 4096;
  localparam logic [23:0] HOT_DRIVE   = 24'd328458;
  localparam logic [63:0] HOT_PEAK    = 64'd8220835;
  localparam int          IDLE_LIMIT  = 1000;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          LONG_BLOCK  = 200;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t sample_beat = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result_beat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state
  cfg_t chain_setup;
  longint tap_in [2][2];
  longint tap_out [2][2];
  logic [63:0] energy_acc [2];
  logic [63:0] peak_acc [2];
  int frames_in_block;
  result_t expected_results [$];

  int mismatches = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int reports_checked = 0;
  int setups_loaded = 0;
  int idle_cycles = 0;
  int gap_before = 0;
  bit in_free = 0;
  bit out_free = 0;

  soft_clip_biquad_meter dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(sample_beat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic void clear_chain_state();
    chain_setup = '0;
    chain_setup.drive_gain = 24'd65536;
    chain_setup.makeup_gain = 17'd65536;
    chain_setup.coef_b0 = 32'sd1073741824;
    for (int c = 0; c < 2; c++) begin
      tap_in[c][0] = 0;
      tap_in[c][1] = 0;
      tap_out[c][0] = 0;
      tap_out[c][1] = 0;
      energy_acc[c] = '0;
      peak_acc[c] = '0;
    end
    frames_in_block = 0;
  endfunction

  // drive, cubic shaping, makeup gain
  function automatic longint soft_clip(input logic signed [23:0] smp);
    longint x, drv, mk, u, k, s;
    logic [63:0] m, sq, c;
    x = longint'(smp);
    drv = longint'(chain_setup.drive_gain);
    mk = longint'(chain_setup.makeup_gain);
    u = (x * drv) >>> 16;
    m = (u < 0) ? -u : u;
    sq = (m * m) >> 23;
    c = (sq * (m >> 12) + ((sq * (m & 64'hFFF)) >> 12)) >> 11;
    k = longint'((CUBE_K * c) >> 16);
    s = (u < 0) ? u + k : u - k;
    if (s > CLIP_LIMIT) s = CLIP_LIMIT;
    else if (s < -CLIP_LIMIT) s = -CLIP_LIMIT;
    return clamp24((s * mk) >>> 16);
  endfunction

  function automatic void predict_sample(input item_t it);
    longint f, acc, y;
    int ch;
    logic [63:0] mag, e, pk;
    result_t r;
    ch = int'(it.channel_in);
    f = soft_clip(it.sample_in);
    acc = chain_setup.coef_b0 * f + chain_setup.coef_b1 * tap_in[ch][0]
        + chain_setup.coef_b2 * tap_in[ch][1] - chain_setup.coef_a1 * tap_out[ch][0]
        - chain_setup.coef_a2 * tap_out[ch][1];
    y = clamp24(acc >>> 30);
    tap_in[ch][1] = tap_in[ch][0];
    tap_in[ch][0] = f;
    tap_out[ch][1] = tap_out[ch][0];
    tap_out[ch][0] = y;

    mag = (y < 0) ? -y : y;
    e = energy_acc[ch] + mag * mag;
    energy_acc[ch] = (e > ENERGY_CAP) ? ENERGY_CAP : e;
    if (mag > peak_acc[ch]) peak_acc[ch] = mag;
    if (ch == 1 && frames_in_block < FRAME_LIMIT) frames_in_block++;

    r = '0;
    r.result_kind = KIND_SAMPLE;
    r.sample_out = y[23:0];
    r.channel_out = it.channel_in;
    r.run_last = !it.block_end;
    expected_results.push_back(r);
    if (!it.block_end) return;

    pk = (peak_acc[0] > peak_acc[1]) ? peak_acc[0] : peak_acc[1];
    r = '0;
    r.result_kind = KIND_REPORT;
    r.energy_left = energy_acc[0][57:0];
    r.energy_right = energy_acc[1][57:0];
    r.peak_left = peak_acc[0][23:0];
    r.peak_right = peak_acc[1][23:0];
    r.frame_count = 13'(frames_in_block);
    r.clip_flag = (chain_setup.drive_gain > HOT_DRIVE) && (pk > HOT_PEAK);
    r.run_last = 1'b1;
    expected_results.push_back(r);
    energy_acc[0] = '0;
    energy_acc[1] = '0;
    peak_acc[0] = '0;
    peak_acc[1] = '0;
    frames_in_block = 0;
  endfunction

  task automatic send_sample(input logic signed [23:0] smp, input logic ch,
                             input logic last);
    item_t it;
    it.sample_in = smp;
    it.channel_in = ch;
    it.block_end = last;
    if (gap_before != 0) repeat (gap_before) @(posedge clk);
    item_valid <= 1'b1;
    sample_beat <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_sample(it);
    samples_sent++;
    gap_before = in_free ? 0 : $urandom_range(0, 9);
    if (gap_before != 0) item_valid <= 1'b0;
  endtask

  task automatic drain_results();
    if (gap_before == 0) item_valid <= 1'b0;
    gap_before = 1;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DRIVE:  chain_setup.drive_gain = data[23:0];
      REG_MAKEUP: chain_setup.makeup_gain = data[16:0];
      REG_B0:     chain_setup.coef_b0 = data;
      REG_B1:     chain_setup.coef_b1 = data;
      REG_B2:     chain_setup.coef_b2 = data;
      REG_A1:     chain_setup.coef_a1 = data;
      REG_A2:     chain_setup.coef_a2 = data;
      default: ;
    endcase
  endtask

  task automatic load_setup(input cfg_t s);
    drain_results();
    write_reg(REG_DRIVE, {8'($urandom()), s.drive_gain});
    write_reg(REG_MAKEUP, {15'($urandom()), s.makeup_gain});
    write_reg(REG_B0, s.coef_b0);
    write_reg(REG_B1, s.coef_b1);
    write_reg(REG_B2, s.coef_b2);
    write_reg(REG_A1, s.coef_a1);
    write_reg(REG_A2, s.coef_a2);
    write_reg(REG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
    setups_loaded++;
  endtask

  function automatic cfg_t random_setup();
    cfg_t s;
    int flavor;
    flavor = $urandom_range(0, 2);
    s.coef_b0 = $urandom_range(32'h0800_0000, 32'h4000_0000);
    s.coef_b1 = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
    s.coef_b2 = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
    s.coef_a1 = -$urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
    s.coef_a2 = $urandom_range(0, 32'h3FFF_FFFF);
    case (flavor)
      0: begin
        s.drive_gain = 24'($urandom_range(16384, 600000));
        s.makeup_gain = (s.drive_gain <= 24'd65536) ? 17'd65536
                      : 17'(64'h1_0000_0000 / s.drive_gain);
      end
      1: begin
        s.drive_gain = 24'($urandom());
        s.makeup_gain = 17'($urandom_range(0, 131071));
        s.coef_b0 = $urandom();
        s.coef_b1 = $urandom();
        s.coef_b2 = $urandom();
        s.coef_a1 = $urandom();
        s.coef_a2 = $urandom();
      end
      default: begin
        s.drive_gain = 24'($urandom_range(328459, 24'hFFFFFF));
        s.makeup_gain = 17'($urandom_range(0, 131071));
        s.coef_b0 = $urandom_range(32'h2000_0000, 32'h7FFF_FFFF);
      end
    endcase
    return s;
  endfunction

  function automatic logic signed [23:0] random_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2, 3, 4: return 24'($urandom_range(0, 8191)) - 24'd4096;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // result side: random stall per beat, then compare with the oldest prediction
  initial begin
    int n;
    result_t want;
    wait (rst == 1'b0);
    forever begin
      n = out_free ? 0 : $urandom_range(0, 9);
      if (n != 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 64'(want.result_kind), 64'(result_beat.result_kind));
        check_field("sample_out", 64'(want.sample_out), 64'(result_beat.sample_out));
        check_field("channel_out", 64'(want.channel_out), 64'(result_beat.channel_out));
        check_field("energy_left", 64'(want.energy_left), 64'(result_beat.energy_left));
        check_field("energy_right", 64'(want.energy_right),
                    64'(result_beat.energy_right));
        check_field("peak_left", 64'(want.peak_left), 64'(result_beat.peak_left));
        check_field("peak_right", 64'(want.peak_right), 64'(result_beat.peak_right));
        check_field("frame_count", 64'(want.frame_count), 64'(result_beat.frame_count));
        check_field("clip_flag", 64'(want.clip_flag), 64'(result_beat.clip_flag));
        check_field("run_last", 64'(want.run_last), 64'(result_beat.run_last));
        results_checked++;
        if (want.result_kind == KIND_REPORT) reports_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no beat moved for %0d cycles, %0d results pending", idle_cycles,
               expected_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(24'sh000000, LEFT, 1'b0);
    send_sample(24'sh000000, RIGHT, 1'b0);
    send_sample(24'sh7FFFFF, LEFT, 1'b0);
    send_sample(24'sh800000, RIGHT, 1'b0);
    send_sample(24'sh000001, LEFT, 1'b0);
    send_sample(24'shFFFFFF, RIGHT, 1'b1);
  endtask

  task automatic test_gain_extremes();
    cfg_t s;
    s.drive_gain = 24'hFFFFFF;
    s.makeup_gain = 17'd131071;
    s.coef_b0 = 32'sh7FFF_FFFF;
    s.coef_b1 = 32'sh8000_0000;
    s.coef_b2 = 32'sh7FFF_FFFF;
    s.coef_a1 = 32'sh8000_0000;
    s.coef_a2 = 32'sh7FFF_FFFF;
    load_setup(s);
    send_sample(24'sh7FFFFF, LEFT, 1'b0);
    send_sample(24'sh800000, RIGHT, 1'b0);
    send_sample(24'sh003039, LEFT, 1'b0);
    send_sample(24'sh800000, RIGHT, 1'b1);
    s.drive_gain = 24'd0;
    s.makeup_gain = 17'd0;
    s.coef_b0 = 32'sh8000_0000;
    s.coef_b1 = 32'sh8000_0000;
    s.coef_b2 = 32'sh8000_0000;
    s.coef_a1 = 32'sh8000_0000;
    s.coef_a2 = 32'sh8000_0000;
    load_setup(s);
    send_sample(24'sh7FFFFF, LEFT, 1'b0);
    send_sample(24'shFFFFFF, RIGHT, 1'b0);
    send_sample(24'sh800000, RIGHT, 1'b1);
  endtask

  // clip flag needs drive strictly above 14 dB and a hot peak
  task automatic test_clip_threshold();
    cfg_t s;
    s = '0;
    s.drive_gain = HOT_DRIVE;
    s.makeup_gain = 17'd65536;
    s.coef_b0 = 32'sh7FFF_FFFF;
    load_setup(s);
    send_sample(24'sh800000, RIGHT, 1'b1);
    s.drive_gain = HOT_DRIVE + 24'd1;
    load_setup(s);
    send_sample(24'sh800000, RIGHT, 1'b1);
    s.drive_gain = 24'hFFFFFF;
    s.coef_b0 = 32'sh4000_0000;
    load_setup(s);
    send_sample(24'sh000001, LEFT, 1'b1);
  endtask

  // one long full-scale block, mostly right samples, no gaps on either side
  task automatic test_long_block();
    cfg_t s;
    s = '0;
    s.drive_gain = 24'd65536;
    s.makeup_gain = 17'd65536;
    s.coef_b0 = 32'sh7FFF_FFFF;
    load_setup(s);
    in_free = 1;
    out_free = 1;
    for (int i = 0; i < LONG_BLOCK; i++) send_sample(24'sh800000, RIGHT, 1'b0);
    send_sample(24'sh7FFFFF, LEFT, 1'b0);
    send_sample(24'sh800000, LEFT, 1'b0);
    send_sample(24'sh800000, RIGHT, 1'b1);
    in_free = 0;
    out_free = 0;
  endtask

  task automatic test_random_stream();
    int sent;
    int frames;
    int burst;
    for (int phase = 0; phase < 8; phase++) begin
      load_setup(random_setup());
      sent = 0;
      while (sent < 120) begin
        in_free = ($urandom_range(0, 3) == 0);
        out_free = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 8) begin
          frames = $urandom_range(1, 24);
          for (int f = 0; f < frames; f++) begin
            send_sample(random_sample(), LEFT, 1'b0);
            send_sample(random_sample(), RIGHT, f == frames - 1);
          end
          sent += 2 * frames;
        end else begin
          burst = $urandom_range(1, 12);
          for (int i = 0; i < burst; i++)
            send_sample(random_sample(), 1'($urandom()), $urandom_range(0, 4) == 0);
          sent += burst;
        end
      end
    end
    in_free = 0;
    out_free = 0;
  endtask

  initial begin
    clear_chain_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_gain_extremes();
    test_clip_threshold();
    test_long_block();
    test_random_stream();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples under %0d register setups, incl. one long gapless block.",
             samples_sent, setups_loaded);
    $display("Checked %0d results, %0d of them block reports.", results_checked,
             reports_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
